// File: design/thread_sync_unit_top_defines.svh
// Assertion macros used by the checker file.
`ifndef THREAD_SYNC_UNIT_TOP_DEFINES_SVH
`define THREAD_SYNC_UNIT_TOP_DEFINES_SVH

// Overlapping implication, sampled on clock, off during reset.
`define TSU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Non-overlapping implication, sampled on clock, off during reset.
`define TSU_ASSERT_NIMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/tsu_pkg.sv
package tsu_pkg;

   localparam int CNT_W           = 7;
   localparam int REGION_W        = 4;
   localparam int CMD_W           = 3;
   localparam int DEF_REGIONS     = 16;
   localparam int DEF_MAX_THREADS = 64;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_SINGLE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ARRIVE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POLL    = 3'd4;

   typedef enum logic [2:0] {
      OP_SINGLE,
      OP_ACQUIRE,
      OP_RELEASE,
      OP_ARRIVE,
      OP_POLL,
      OP_BAD_CMD,
      OP_BAD_REGION
   } tsu_op_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [REGION_W-1:0] region;
      logic                expected_phase;
   } tsu_req_type;

   typedef struct packed {
      logic ok;
      logic phase;
      logic error;
   } tsu_rsp_type;

   typedef struct packed {
      tsu_op_type          op;
      logic [REGION_W-1:0] region;
      logic                expected_phase;
   } tsu_item_type;

endpackage

// File: design/tsu_front.sv
module tsu_front #(
   parameter int REGIONS = 16
) (
   input  logic                  start,
   input  logic                  queue_full,
   input  tsu_pkg::tsu_req_type  req_data,
   output logic                  busy,
   output logic                  push,
   output tsu_pkg::tsu_item_type item
);
   import tsu_pkg::*;

   tsu_op_type op;

   always_comb begin
      if (int'(req_data.region) >= REGIONS) begin
         op = OP_BAD_REGION;
      end else begin
         case (req_data.cmd)
            CMD_SINGLE:  op = OP_SINGLE;
            CMD_ACQUIRE: op = OP_ACQUIRE;
            CMD_RELEASE: op = OP_RELEASE;
            CMD_ARRIVE:  op = OP_ARRIVE;
            CMD_POLL:    op = OP_POLL;
            default:     op = OP_BAD_CMD;
         endcase
      end
   end

   assign busy                = queue_full;
   assign push                = start && !queue_full;
   assign item.op             = op;
   assign item.region         = req_data.region;
   assign item.expected_phase = req_data.expected_phase;

endmodule

// File: design/tsu_queue.sv
module tsu_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tsu_pkg::tsu_item_type push_item,
   input  logic                  pop,
   output logic                  empty,
   output logic                  full,
   output tsu_pkg::tsu_item_type head_item
);
   import tsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   tsu_item_type      entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_QW'(DEPTH));
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/tsu_back.sv
module tsu_back #(
   parameter int REGIONS     = 16,
   parameter int MAX_THREADS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  tsu_pkg::tsu_item_type         item,
   input  logic                          csr_write_en,
   input  logic [tsu_pkg::CNT_W-1:0]     csr_write_data,
   output logic                          pop,
   output logic                          rsp_strobe,
   output tsu_pkg::tsu_rsp_type          rsp_data
);
   import tsu_pkg::*;

   localparam int RIDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

   logic [CNT_W-1:0] thread_count_ff, thread_count_in;
   logic [CNT_W-1:0] tally_ff [REGIONS];
   logic             lock_free_ff [REGIONS];
   logic             phase_ff [REGIONS];
   logic [CNT_W-1:0] remain_ff [REGIONS][2];
   logic             rsp_strobe_ff;
   tsu_rsp_type      rsp_data_ff, rsp_data_in;

   logic [RIDX_W-1:0] idx;
   logic              ph;
   logic [CNT_W-1:0]  seen, cnt;
   logic [CNT_W:0]    seen_inc;
   logic              tally_we, lock_we, phase_we, remain_we;
   logic [CNT_W-1:0]  tally_in, remain_in;
   logic              lock_in, phase_in;

   always_comb begin
      thread_count_in = csr_write_data;
      if (csr_write_data == '0) begin
         thread_count_in = CNT_W'(1);
      end else if (int'(csr_write_data) > MAX_THREADS) begin
         thread_count_in = CNT_W'(MAX_THREADS);
      end
   end

   assign idx      = RIDX_W'(item.region);
   assign ph       = phase_ff[idx];
   assign seen     = tally_ff[idx];
   assign cnt      = remain_ff[idx][ph];
   assign seen_inc = {1'b0, seen} + 1'b1;

   always_comb begin
      tally_we    = 1'b0;
      lock_we     = 1'b0;
      phase_we    = 1'b0;
      remain_we   = 1'b0;
      tally_in    = '0;
      lock_in     = 1'b0;
      phase_in    = ~ph;
      remain_in   = thread_count_ff;
      rsp_data_in = '{ok: 1'b0, phase: ph, error: 1'b0};
      case (item.op)
         OP_SINGLE: begin
            tally_we       = 1'b1;
            tally_in       = (seen_inc >= {1'b0, thread_count_ff}) ? '0
                                                                  : seen_inc[CNT_W-1:0];
            rsp_data_in.ok = (seen == '0);
         end
         OP_ACQUIRE: begin
            if (lock_free_ff[idx]) begin
               lock_we        = 1'b1;
               lock_in        = 1'b0;
               rsp_data_in.ok = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (lock_free_ff[idx]) begin
               rsp_data_in.error = 1'b1;
            end else begin
               lock_we        = 1'b1;
               lock_in        = 1'b1;
               rsp_data_in.ok = 1'b1;
            end
         end
         OP_ARRIVE: begin
            if (cnt == '0) begin
               rsp_data_in.error = 1'b1;
            end else if (cnt == CNT_W'(1)) begin
               remain_we      = 1'b1;
               remain_in      = thread_count_ff;
               phase_we       = 1'b1;
               rsp_data_in.ok = 1'b1;
            end else begin
               remain_we = 1'b1;
               remain_in = cnt - 1'b1;
            end
         end
         OP_POLL: begin
            rsp_data_in.ok = (ph != item.expected_phase);
         end
         OP_BAD_REGION: begin
            rsp_data_in = '{ok: 1'b0, phase: 1'b0, error: 1'b1};
         end
         default: begin
            rsp_data_in.error = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thread_count_ff <= CNT_W'(1);
         rsp_strobe_ff   <= 1'b0;
         for (int r = 0; r < REGIONS; r++) begin
            tally_ff[r]     <= '0;
            lock_free_ff[r] <= 1'b1;
            phase_ff[r]     <= 1'b0;
            remain_ff[r][0] <= CNT_W'(1);
            remain_ff[r][1] <= CNT_W'(1);
         end
      end else begin
         rsp_strobe_ff <= item_valid && !csr_write_en;
         if (csr_write_en) begin
            thread_count_ff <= thread_count_in;
            for (int r = 0; r < REGIONS; r++) begin
               tally_ff[r]     <= '0;
               remain_ff[r][0] <= thread_count_in;
               remain_ff[r][1] <= thread_count_in;
            end
         end else if (item_valid) begin
            if (tally_we) begin
               tally_ff[idx] <= tally_in;
            end
            if (lock_we) begin
               lock_free_ff[idx] <= lock_in;
            end
            if (phase_we) begin
               phase_ff[idx] <= phase_in;
            end
            if (remain_we) begin
               remain_ff[idx][ph] <= remain_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign pop        = item_valid && !csr_write_en;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: design/thread_sync_unit_top.sv
// Thread synchronization unit: per-region single-task counter, test-and-set
// lock and sense-reversing barrier.
// Request channel: a beat is taken at a clock edge with start high and busy
// low; req_data carries cmd, region and expected_phase.
// Result channel: every request gives one result beat, shown on rsp_data for
// one cycle with rsp_strobe high. The receiver cannot stall it.
// Result path: the request is written into the queue, then the back end does
// one read-modify-write of the region record and registers the result beat
// on rsp_strobe and rsp_data.
// Throughput: one request per cycle; the back end retires one queue entry
// each cycle with csr_write_en low, so busy rises only if the queue fills.
// Config: csr_write_en with csr_write_data sets the thread count (0 reads as
// 1, values above MAX_THREADS clip), reloads all barrier counts and clears
// all single-task tallies. Write only while no request is in flight.
// Reset: thread count 1, all locks free, all phases 0, tallies 0, barrier
// counts 1, queue empty.
module thread_sync_unit_top #(
   parameter int REGIONS     = tsu_pkg::DEF_REGIONS,
   parameter int MAX_THREADS = tsu_pkg::DEF_MAX_THREADS,
   parameter int QUEUE_DEPTH = tsu_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  tsu_pkg::tsu_req_type      req_data,
   output logic                      rsp_strobe,
   output tsu_pkg::tsu_rsp_type      rsp_data,
   input  logic                      csr_write_en,
   input  logic [tsu_pkg::CNT_W-1:0] csr_write_data
);
   import tsu_pkg::*;

   tsu_item_type push_item, head_item;
   logic         push, pop, q_empty, q_full;

   tsu_front #(.REGIONS(REGIONS)) u_front (
      .start      (start),
      .queue_full (q_full),
      .req_data   (req_data),
      .busy       (busy),
      .push       (push),
      .item       (push_item)
   );

   tsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .empty     (q_empty),
      .full      (q_full),
      .head_item (head_item)
   );

   tsu_back #(.REGIONS(REGIONS), .MAX_THREADS(MAX_THREADS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (!q_empty),
      .item           (head_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data)
   );

endmodule

// File: design/tsu_checker.sv
`include "thread_sync_unit_top_defines.svh"

module tsu_checker #(
   parameter int REGIONS = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input tsu_pkg::tsu_req_type      req_data,
   input logic                      rsp_strobe,
   input tsu_pkg::tsu_rsp_type      rsp_data,
   input logic                      csr_write_en,
   input logic [tsu_pkg::CNT_W-1:0] csr_write_data
);
   import tsu_pkg::*;

   logic accept, valid_region, cfg_quiet;

   assign accept       = start && !busy;
   assign valid_region = int'(req_data.region) < REGIONS;
   assign cfg_quiet    = !csr_write_en && (csr_write_data == csr_write_data);

   `TSU_ASSERT_NIMP(a_beat_answered, accept && cfg_quiet, ##1 rsp_strobe, "request beat lost")

   `TSU_ASSERT_NIMP(a_bad_cmd_error, accept && (req_data.cmd > CMD_POLL),
      ##1 (rsp_data.error && !rsp_data.ok), "unknown command not flagged")

   `TSU_ASSERT_NIMP(a_poll_no_error, accept && valid_region && (req_data.cmd == CMD_POLL),
      ##1 !rsp_data.error, "poll flagged an error")

   `TSU_ASSERT_NIMP(a_lock_held,
      accept && (req_data.cmd == CMD_ACQUIRE) ##1
      accept && (req_data.cmd == CMD_ACQUIRE) && (req_data.region == $past(req_data.region)),
      ##1 !rsp_data.ok, "second acquire of a held lock granted")

endmodule

bind thread_sync_unit_top tsu_checker #(.REGIONS(REGIONS)) u_tsu_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tsu_pkg::*;

   localparam int                NUM_REGIONS = DEF_REGIONS;
   localparam int                THREAD_MAX  = DEF_MAX_THREADS;
   localparam logic [CMD_W-1:0]  CMD_TOP     = {CMD_W{1'b1}};
   localparam logic [CNT_W-1:0]  CSR_ALL_ONE = {CNT_W{1'b1}};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   tsu_req_type       req_data = '0;
   logic              rsp_strobe;
   tsu_rsp_type       rsp_data;
   logic              csr_write_en = 1'b0;
   logic [CNT_W-1:0]  csr_write_data = '0;

   thread_sync_unit_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the per-region control blocks
   int          threads;
   int          tally    [NUM_REGIONS];
   logic        lock_free[NUM_REGIONS];
   logic        bar_phase[NUM_REGIONS];
   int          remaining[2*NUM_REGIONS];

   tsu_req_type pending_reqs[$];
   tsu_rsp_type awaited_rsps[$];

   int beats_sent   = 0;
   int rsps_checked = 0;
   int mismatches   = 0;
   int csr_writes   = 0;

   function automatic void reload_counts();
      for (int i = 0; i < 2*NUM_REGIONS; i++) remaining[i] = threads;
      for (int i = 0; i < NUM_REGIONS; i++) tally[i] = 0;
   endfunction

   function automatic void set_threads(logic [CNT_W-1:0] v);
      threads = (v == 0) ? 1 : (int'(v) > THREAD_MAX) ? THREAD_MAX : int'(v);
      reload_counts();
   endfunction

   function automatic tsu_rsp_type resolve_request(tsu_req_type rq);
      tsu_rsp_type r;
      int          rg;
      int          slot;
      r  = '0;
      rg = int'(rq.region);
      if (rg >= NUM_REGIONS) begin
         r.error = 1'b1;
         return r;
      end
      r.phase = bar_phase[rg];
      case (rq.cmd)
         CMD_SINGLE: begin
            r.ok = (tally[rg] == 0);
            tally[rg] = (tally[rg] + 1 >= threads) ? 0 : tally[rg] + 1;
         end
         CMD_ACQUIRE: begin
            if (lock_free[rg]) begin
               lock_free[rg] = 1'b0;
               r.ok = 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (lock_free[rg]) begin
               r.error = 1'b1;
            end else begin
               lock_free[rg] = 1'b1;
               r.ok = 1'b1;
            end
         end
         CMD_ARRIVE: begin
            slot = rg * 2 + int'(bar_phase[rg]);
            if (remaining[slot] == 0) begin
               r.error = 1'b1;
            end else if (remaining[slot] == 1) begin
               remaining[slot] = threads;
               bar_phase[rg] = ~bar_phase[rg];
               r.ok = 1'b1;
            end else begin
               remaining[slot] = remaining[slot] - 1;
            end
         end
         CMD_POLL: r.ok = (bar_phase[rg] != rq.expected_phase);
         default:  r.error = 1'b1;
      endcase
      return r;
   endfunction

   // driver: bursts of beats with random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_rsps.push_back(resolve_request(req_data));
            void'(pending_reqs.pop_front());
            beats_sent++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5: gap_left = 0;
                  6:                gap_left = $urandom_range(10, 30);
                  default:          gap_left = $urandom_range(1, 8);
               endcase
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            start    <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tsu_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsps.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat ok=%0b phase=%0b error=%0b",
                     $time, rsp_data.ok, rsp_data.phase, rsp_data.error);
         end else begin
            want = awaited_rsps.pop_front();
            rsps_checked++;
            if (rsp_data.ok !== want.ok) begin
               mismatches++;
               $display("%0t: ok mismatch, expected %0b got %0b",
                        $time, want.ok, rsp_data.ok);
            end
            if (rsp_data.phase !== want.phase) begin
               mismatches++;
               $display("%0t: phase mismatch, expected %0b got %0b",
                        $time, want.phase, rsp_data.phase);
            end
            if (rsp_data.error !== want.error) begin
               mismatches++;
               $display("%0t: error mismatch, expected %0b got %0b",
                        $time, want.error, rsp_data.error);
            end
         end
      end
   end

   function automatic void queue_req(logic [CMD_W-1:0] c, int rg, logic ep);
      tsu_req_type rq;
      rq.cmd            = c;
      rq.region         = rg[REGION_W-1:0];
      rq.expected_phase = ep;
      pending_reqs.push_back(rq);
   endfunction

   function automatic int pick_region();
      return ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                        : $urandom_range(0, NUM_REGIONS-1);
   endfunction

   function automatic int noise_beat(int rg);
      queue_req(CMD_W'($urandom_range(0, int'(CMD_TOP))), rg, 1'($urandom_range(0, 1)));
      return 1;
   endfunction

   // well-formed episodes with random content, plus broken ones and noise
   function automatic int queue_episode();
      int rg;
      int n;
      int cnt;
      rg  = pick_region();
      cnt = 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, threads) : threads;
            for (int i = 0; i < n; i++) begin
               queue_req(CMD_ARRIVE, rg, 1'b0);
               cnt++;
               if ($urandom_range(0, 3) == 0) begin
                  queue_req(CMD_POLL, rg, 1'($urandom_range(0, 1)));
                  cnt++;
               end
            end
            queue_req(CMD_POLL, rg, 1'($urandom_range(0, 1)));
            cnt++;
         end
         4, 5: begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, threads) : threads;
            for (int i = 0; i < n; i++) begin
               queue_req(CMD_SINGLE, rg, 1'($urandom_range(0, 1)));
               cnt++;
            end
         end
         6, 7: begin
            if ($urandom_range(0, 3) != 0) begin
               queue_req(CMD_ACQUIRE, rg, 1'($urandom_range(0, 1)));
               cnt++;
            end
            for (int i = $urandom_range(0, 3); i > 0; i--) begin
               queue_req(($urandom_range(0, 1) != 0) ? CMD_ACQUIRE : CMD_POLL,
                         rg, 1'($urandom_range(0, 1)));
               cnt++;
            end
            queue_req(CMD_RELEASE, rg, 1'($urandom_range(0, 1)));
            cnt++;
         end
         default: begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
               cnt += noise_beat($urandom_range(0, NUM_REGIONS-1));
         end
      endcase
      return cnt;
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || start || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threads(logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      set_threads(v);
      csr_writes++;
   endtask

   logic [CNT_W-1:0] settings[$];

   initial begin
      int budget;
      threads = 1;
      for (int i = 0; i < NUM_REGIONS; i++) begin
         lock_free[i] = 1'b1;
         bar_phase[i] = 1'b0;
      end
      reload_counts();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: one thread
      queue_req(CMD_SINGLE,  0,  1'b0);
      queue_req(CMD_SINGLE,  0,  1'b1);
      queue_req(CMD_ACQUIRE, 15, 1'b0);
      queue_req(CMD_ACQUIRE, 15, 1'b1);
      queue_req(CMD_RELEASE, 15, 1'b0);
      queue_req(CMD_RELEASE, 15, 1'b1);
      queue_req(CMD_ARRIVE,  0,  1'b0);
      queue_req(CMD_POLL,    0,  1'b0);
      queue_req(CMD_POLL,    0,  1'b1);
      queue_req(CMD_POLL,    7,  1'b0);
      queue_req(CMD_POLL + 3'd1, 3, 1'b0);
      queue_req(CMD_TOP - 3'd1, 12, 1'b1);
      queue_req(CMD_TOP,      9, 1'b1);
      drain();

      // directed: three threads
      write_threads(7'd3);
      for (int i = 0; i < 4; i++) queue_req(CMD_SINGLE, 5, 1'b0);
      queue_req(CMD_ARRIVE, 5, 1'b0);
      queue_req(CMD_ARRIVE, 5, 1'b0);
      queue_req(CMD_POLL,   5, 1'b0);
      queue_req(CMD_ARRIVE, 5, 1'b0);
      queue_req(CMD_POLL,   5, 1'b0);
      drain();

      settings = '{7'd0, CSR_ALL_ONE, 7'd64, 7'd65, 7'd2, 7'd1, 7'd5, 7'd17,
                   7'($urandom_range(1, 127)), 7'($urandom_range(1, 8))};
      foreach (settings[k]) begin
         write_threads(settings[k]);
         budget = 128;
         while (budget > 0) budget -= queue_episode();
         drain();
      end

      repeat (10) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time, awaited_rsps.size());
      end
      $display("Sent %0d request beats and checked %0d results over %0d thread-count settings.",
               beats_sent, rsps_checked, csr_writes);
      if (mismatches == 0) begin
         $display("** thread_sync_unit_top: PASSED **");
      end else begin
         $display("Mismatches: %0d", mismatches);
         $display("** thread_sync_unit_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("** thread_sync_unit_top: FAILED **");
      $finish;
   end

endmodule

// File: thread_sync_unit_top.f
+incdir+design
design/tsu_pkg.sv
design/tsu_front.sv
design/tsu_queue.sv
design/tsu_back.sv
design/thread_sync_unit_top.sv
design/tsu_checker.sv
bench/testbench.sv
